### rtl/core/cbp_pkg.sv
// Shared types, codes and helpers for the configurable branch predictor.
package cbp_pkg;

    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_GSHARE = 2'd1;
    localparam logic [1:0] MODE_LOCAL  = 2'd2;
    localparam logic [1:0] MODE_TOURN  = 2'd3;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_GHB   = 2'd1;
    localparam logic [1:0] CFG_LHB   = 2'd2;
    localparam logic [1:0] CFG_PCB   = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [1:0] CTR_STRONG_T = 2'd3;
    localparam logic [1:0] CTR_STRONG_NT = 2'd0;

    localparam logic [CFG_DATA_W-1:0] RST_GHB = 4'd13;
    localparam logic [CFG_DATA_W-1:0] RST_LHB = 4'd10;
    localparam logic [CFG_DATA_W-1:0] RST_PCB = 4'd10;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_hist;
        logic rd_ctr;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_busy;
    } t_status;

    function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
        logic [1:0] r;
        r = c;
        if (up) begin
            if (c != CTR_STRONG_T) r = c + 2'd1;
        end else begin
            if (c != CTR_STRONG_NT) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

### rtl/core/cbp_ctrl.sv
// Controller state machine: clearing sweep, accept, table reads, update or result.
module cbp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  cbp_pkg::t_status i_status,
    output cbp_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd_hist = 1'b1;
                n_state       = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_ctr = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (!i_status.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_RD1))
        else $error("accepted word did not start a table read");

    a_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |=> (r_state == S_RD2))
        else $error("counter read did not follow history read");

    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_status.out_busy) |=> (r_state == S_EXEC))
        else $error("update issued while result still pending");

    a_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("input taken during clearing sweep");

endmodule

### rtl/core/cbp_datapath.sv
// Datapath: config registers, history, counter tables and result register.
module cbp_datapath #(
    parameter int unsigned MAX_GHIST_BITS = 13,
    parameter int unsigned MAX_LHIST_BITS = 11,
    parameter int unsigned MAX_PC_BITS    = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cbp_pkg::t_cmd                   i_cmd,
    output cbp_pkg::t_status                o_status,
    input  logic                            i_req_type,
    input  logic [31:0]                     i_pc,
    input  logic                            i_taken,
    input  logic                            i_cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic                            o_predict_taken
);

    localparam int unsigned GW = MAX_GHIST_BITS;
    localparam int unsigned LW = MAX_LHIST_BITS;
    localparam int unsigned PW = MAX_PC_BITS;
    localparam int unsigned CW = (GW > LW) ? ((GW > PW) ? GW : PW)
                                           : ((LW > PW) ? LW : PW);

    logic [1:0]                      r_mode;
    logic [cbp_pkg::CFG_DATA_W-1:0]  r_ghb;
    logic [cbp_pkg::CFG_DATA_W-1:0]  r_lhb;
    logic [cbp_pkg::CFG_DATA_W-1:0]  r_pcb;

    logic        r_req;
    logic [31:0] r_pc;
    logic        r_taken;

    logic [GW-1:0] r_ghist;
    logic [CW-1:0] r_clr_cnt;

    logic [GW-1:0] r_gidx;
    logic [GW-1:0] r_cidx;
    logic [PW-1:0] r_slot;
    logic [LW-1:0] r_lidx;

    logic [1:0]    r_gc_mem [2**GW];
    logic [1:0]    r_ch_mem [2**GW];
    logic [LW-1:0] r_lh_mem [2**PW];
    logic [1:0]    r_lc_mem [2**LW];

    logic [1:0]    r_gc_rd;
    logic [1:0]    r_ch_rd;
    logic [LW-1:0] r_lh_rd;
    logic [1:0]    r_lc_rd;

    logic          r_out_valid;
    logic          r_out_taken;

    logic [GW-1:0] gmask;
    logic [LW-1:0] lmask;
    logic [PW-1:0] pmask;
    logic [GW-1:0] gc_ra;
    logic [GW-1:0] hist_idx;
    logic [PW-1:0] slot;
    logic [LW-1:0] lidx;

    logic gp;
    logic lp;
    logic pred;
    logic gc_up;
    logic ch_up;
    logic loc_up;

    logic          gc_we;
    logic [GW-1:0] gc_wa;
    logic [1:0]    gc_wd;
    logic          ch_we;
    logic [GW-1:0] ch_wa;
    logic [1:0]    ch_wd;
    logic          lh_we;
    logic [PW-1:0] lh_wa;
    logic [LW-1:0] lh_wd;
    logic          lc_we;
    logic [LW-1:0] lc_wa;
    logic [1:0]    lc_wd;

    always_comb begin
        for (int i = 0; i < int'(GW); i++) gmask[i] = (i < int'(r_ghb));
        for (int i = 0; i < int'(LW); i++) lmask[i] = (i < int'(r_lhb));
        for (int i = 0; i < int'(PW); i++) pmask[i] = (i < int'(r_pcb));
    end

    assign hist_idx = r_ghist & gmask;
    assign gc_ra    = (r_mode == cbp_pkg::MODE_GSHARE) ? ((r_ghist ^ r_pc[GW-1:0]) & gmask)
                                                       : hist_idx;
    assign slot     = r_pc[PW-1:0] & pmask;
    assign lidx     = r_lh_rd & lmask;

    always_comb begin
        gp     = r_gc_rd[1];
        lp     = r_lc_rd[1];
        gc_up  = r_req && (r_mode inside {cbp_pkg::MODE_GSHARE, cbp_pkg::MODE_TOURN});
        loc_up = r_req && (r_mode inside {cbp_pkg::MODE_LOCAL, cbp_pkg::MODE_TOURN});
        ch_up  = r_req && (r_mode == cbp_pkg::MODE_TOURN) && (gp != lp);
        case (r_mode)
            cbp_pkg::MODE_GSHARE: pred = gp;
            cbp_pkg::MODE_LOCAL:  pred = lp;
            cbp_pkg::MODE_TOURN:  pred = r_ch_rd[1] ? lp : gp;
            default:              pred = 1'b1;
        endcase
    end

    always_comb begin
        gc_we = i_cmd.clr_step || (i_cmd.exec && gc_up);
        gc_wa = i_cmd.clr_step ? r_clr_cnt[GW-1:0] : r_gidx;
        gc_wd = i_cmd.clr_step ? cbp_pkg::CTR_WEAK_NT : cbp_pkg::bump(r_gc_rd, r_taken);
        ch_we = i_cmd.clr_step || (i_cmd.exec && ch_up);
        ch_wa = i_cmd.clr_step ? r_clr_cnt[GW-1:0] : r_cidx;
        ch_wd = i_cmd.clr_step ? cbp_pkg::CTR_WEAK_NT : cbp_pkg::bump(r_ch_rd, lp == r_taken);
        lh_we = i_cmd.clr_step || (i_cmd.exec && loc_up);
        lh_wa = i_cmd.clr_step ? r_clr_cnt[PW-1:0] : r_slot;
        lh_wd = i_cmd.clr_step ? '0 : ((r_lh_rd << 1) | LW'(r_taken));
        lc_we = i_cmd.clr_step || (i_cmd.exec && loc_up);
        lc_wa = i_cmd.clr_step ? r_clr_cnt[LW-1:0] : r_lidx;
        lc_wd = i_cmd.clr_step ? cbp_pkg::CTR_WEAK_NT : cbp_pkg::bump(r_lc_rd, r_taken);
    end

    always_ff @(posedge i_clk) begin
        if (gc_we) r_gc_mem[gc_wa] <= gc_wd;
        if (i_cmd.rd_hist) r_gc_rd <= r_gc_mem[gc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) r_ch_mem[ch_wa] <= ch_wd;
        if (i_cmd.rd_hist) r_ch_rd <= r_ch_mem[hist_idx];
    end

    always_ff @(posedge i_clk) begin
        if (lh_we) r_lh_mem[lh_wa] <= lh_wd;
        if (i_cmd.rd_hist) r_lh_rd <= r_lh_mem[slot];
    end

    always_ff @(posedge i_clk) begin
        if (lc_we) r_lc_mem[lc_wa] <= lc_wd;
        if (i_cmd.rd_ctr) r_lc_rd <= r_lc_mem[lidx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_pc    <= i_pc;
            r_taken <= i_taken;
        end
        if (i_cmd.rd_hist) begin
            r_gidx <= gc_ra;
            r_cidx <= hist_idx;
            r_slot <= slot;
        end
        if (i_cmd.rd_ctr) r_lidx <= lidx;
        if (i_cmd.exec) r_out_taken <= pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cbp_pkg::MODE_STATIC;
            r_ghb       <= cbp_pkg::RST_GHB;
            r_lhb       <= cbp_pkg::RST_LHB;
            r_pcb       <= cbp_pkg::RST_PCB;
            r_ghist     <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    cbp_pkg::CFG_MODE: r_mode <= i_cfg_wdata[1:0];
                    cbp_pkg::CFG_GHB:  r_ghb  <= i_cfg_wdata;
                    cbp_pkg::CFG_LHB:  r_lhb  <= i_cfg_wdata;
                    cbp_pkg::CFG_PCB:  r_pcb  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.exec && gc_up) r_ghist <= (r_ghist << 1) | GW'(r_taken);
            if (i_cmd.exec && !r_req) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clr_done = (r_clr_cnt == '1);
    assign o_status.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_predict_taken   = r_out_taken;

    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.exec))
        else $error("result appeared without an update step");

endmodule

### rtl/core/configurable_branch_predictor_core.sv
// Top level of the configurable branch direction predictor.
// Each word steps through accept, read of global counter, chooser and local
// history, read of the local counter addressed by that history, then the update
// or the result, held while an earlier result is not yet taken. A new word is
// taken only once the previous one has finished. A predict word returns one
// result word, a train word returns none. After reset the tables are cleared
// one entry per cycle, 2**max(MAX_GHIST_BITS, MAX_LHIST_BITS, MAX_PC_BITS)
// entries (8192 with the defaults), before the first word is taken;
// configuration writes are taken throughout.
module configurable_branch_predictor_core #(
    parameter int unsigned MAX_GHIST_BITS = 13,
    parameter int unsigned MAX_LHIST_BITS = 11,
    parameter int unsigned MAX_PC_BITS    = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,  // pc[31:0], taken, zero pad
    input  logic                            s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // predict_taken, zero pad
    input  logic                            i_cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    cbp_pkg::t_cmd    cmd;
    cbp_pkg::t_status status;
    logic             predict_taken;

    cbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cbp_datapath #(
        .MAX_GHIST_BITS (MAX_GHIST_BITS),
        .MAX_LHIST_BITS (MAX_LHIST_BITS),
        .MAX_PC_BITS    (MAX_PC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (s_axis_tuser),
        .i_pc            (s_axis_tdata[31:0]),
        .i_taken         (s_axis_tdata[32]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .o_predict_taken (predict_taken)
    );

    assign m_axis_tdata = {7'd0, predict_taken};

endmodule
